### rtl/sip_pkg.sv
// package for the segment intersection point block
// holds coordinate widths, payload structs and the inter-stage word types; no dependencies
package sip_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;            // coordinate difference
  localparam int PROD_BITS  = 2 * DIFF_BITS;             // product of two differences
  localparam int CP_BITS    = 2 * COORD_BITS + 1;        // x1*y2 - y1*x2
  localparam int DEN_BITS   = PROD_BITS + 1;             // determinant
  localparam int NUM_BITS   = CP_BITS + DIFF_BITS + 1;   // numerator
  localparam int QUO_BITS   = COORD_BITS + 1;            // magnitude of quotient (fits)
  localparam int DIV_STEPS  = QUO_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic   crosses;
    coord_t cross_x;
    coord_t cross_y;
  } cross_result_t;

  // one division job handed to the shared divider pipeline
  typedef struct packed {
    logic                crosses;
    logic                neg_x;
    logic                neg_y;
    logic [NUM_BITS-1:0] mag_nx;
    logic [NUM_BITS-1:0] mag_ny;
    logic [DEN_BITS-1:0] mag_den;
  } div_job_t;

endpackage

### rtl/sip_geom.sv
// geometry front end: box test, orientation signs, determinant and numerators
// five register stages, no divisions; uses sip_pkg
module sip_geom (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  sip_pkg::seg_pair_t in_word,
  output logic              out_valid,
  output sip_pkg::div_job_t out_job
);
  import sip_pkg::*;

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  // stage a: differences, box test
  logic  va;
  logic  box_a;
  diff_t dx12, dy12, dx34, dy34;
  diff_t ax13, ay13, ax14, ay14, ax31, ay31, ax32, ay32;
  coord_t x1a, y1a, x2a, y2a, x3a, y3a, x4a, y4a;

  function automatic diff_t dsub(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_a <= (cmin(in_word.first_start_x, in_word.first_end_x) <=
                cmax(in_word.second_start_x, in_word.second_end_x)) &&
               (cmin(in_word.second_start_x, in_word.second_end_x) <=
                cmax(in_word.first_start_x, in_word.first_end_x)) &&
               (cmin(in_word.first_start_y, in_word.first_end_y) <=
                cmax(in_word.second_start_y, in_word.second_end_y)) &&
               (cmin(in_word.second_start_y, in_word.second_end_y) <=
                cmax(in_word.first_start_y, in_word.first_end_y));
      dx12 <= dsub(in_word.first_end_x, in_word.first_start_x);
      dy12 <= dsub(in_word.first_end_y, in_word.first_start_y);
      dx34 <= dsub(in_word.second_end_x, in_word.second_start_x);
      dy34 <= dsub(in_word.second_end_y, in_word.second_start_y);
      ax13 <= dsub(in_word.second_start_x, in_word.first_start_x);
      ay13 <= dsub(in_word.second_start_y, in_word.first_start_y);
      ax14 <= dsub(in_word.second_end_x, in_word.first_start_x);
      ay14 <= dsub(in_word.second_end_y, in_word.first_start_y);
      ax31 <= dsub(in_word.first_start_x, in_word.second_start_x);
      ay31 <= dsub(in_word.first_start_y, in_word.second_start_y);
      ax32 <= dsub(in_word.first_end_x, in_word.second_start_x);
      ay32 <= dsub(in_word.first_end_y, in_word.second_start_y);
      x1a <= in_word.first_start_x;  y1a <= in_word.first_start_y;
      x2a <= in_word.first_end_x;    y2a <= in_word.first_end_y;
      x3a <= in_word.second_start_x; y3a <= in_word.second_start_y;
      x4a <= in_word.second_end_x;   y4a <= in_word.second_end_y;
    end
  end

  // stage b: one product per register
  logic  vb, box_b;
  prod_t o3p, o3q, o4p, o4q, o1p, o1q, o2p, o2q, dp, dq;
  logic signed [CP_BITS-2:0] c12p, c12q, c34p, c34q;
  diff_t dx12b, dy12b, dx34b, dy34b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_b <= box_a;
      o3p <= dx12 * ay13;  o3q <= dy12 * ax13;
      o4p <= dx12 * ay14;  o4q <= dy12 * ax14;
      o1p <= dx34 * ay31;  o1q <= dy34 * ax31;
      o2p <= dx34 * ay32;  o2q <= dy34 * ax32;
      // determinant of the ref uses (x1-x2) etc; negating both factors keeps it
      dp  <= dx12 * dy34;  dq  <= dy12 * dx34;
      c12p <= x1a * y2a;   c12q <= y1a * x2a;
      c34p <= x3a * y4a;   c34q <= y3a * x4a;
      dx12b <= dx12; dy12b <= dy12; dx34b <= dx34; dy34b <= dy34;
    end
  end

  // stage c: orientation signs, determinant, cross terms
  logic vc, hit_c;
  logic signed [DEN_BITS-1:0] den_c;
  logic signed [CP_BITS-1:0]  c12, c34;
  diff_t dx12c, dy12c, dx34c, dy34c;
  logic signed [PROD_BITS:0] r3, r4, r1, r2;

  function automatic logic opp(logic signed [PROD_BITS:0] a, logic signed [PROD_BITS:0] b);
    return (a[PROD_BITS] && (b != '0) && !b[PROD_BITS]) ||
           (b[PROD_BITS] && (a != '0) && !a[PROD_BITS]);
  endfunction

  always_comb begin
    r3 = {o3p[PROD_BITS-1], o3p} - {o3q[PROD_BITS-1], o3q};
    r4 = {o4p[PROD_BITS-1], o4p} - {o4q[PROD_BITS-1], o4q};
    r1 = {o1p[PROD_BITS-1], o1p} - {o1q[PROD_BITS-1], o1q};
    r2 = {o2p[PROD_BITS-1], o2p} - {o2q[PROD_BITS-1], o2q};
  end

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_c <= box_b && opp(r3, r4) && opp(r1, r2);
      den_c <= {dp[PROD_BITS-1], dp} - {dq[PROD_BITS-1], dq};
      c12   <= {c12p[CP_BITS-2], c12p} - {c12q[CP_BITS-2], c12q};
      c34   <= {c34p[CP_BITS-2], c34p} - {c34q[CP_BITS-2], c34q};
      dx12c <= dx12b; dy12c <= dy12b; dx34c <= dx34b; dy34c <= dy34b;
    end
  end

  // stage d: numerator products; each carries one reversed difference,
  // so the numerator is formed as q - p below
  logic vd, hit_d;
  logic signed [DEN_BITS-1:0] den_d;
  logic signed [NUM_BITS-2:0] nxp, nxq, nyp, nyq;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_d <= hit_c;
      den_d <= den_c;
      nxp <= c12 * dx34c;  nxq <= dx12c * c34;
      nyp <= c12 * dy34c;  nyq <= dy12c * c34;
    end
  end

  // stage e: numerators, magnitudes and signs
  logic signed [NUM_BITS-1:0] nx, ny;
  always_comb begin
    nx = {nxq[NUM_BITS-2], nxq} - {nxp[NUM_BITS-2], nxp};
    ny = {nyq[NUM_BITS-2], nyq} - {nyp[NUM_BITS-2], nyp};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_job.crosses <= hit_d;
      out_job.neg_x   <= nx[NUM_BITS-1] ^ den_d[DEN_BITS-1];
      out_job.neg_y   <= ny[NUM_BITS-1] ^ den_d[DEN_BITS-1];
      out_job.mag_nx  <= nx[NUM_BITS-1] ? -nx : nx;
      out_job.mag_ny  <= ny[NUM_BITS-1] ? -ny : ny;
      out_job.mag_den <= den_d[DEN_BITS-1] ? -den_d : den_d;
    end
  end

endmodule

### rtl/sip_div.sv
// pipelined restoring divider pair: one quotient bit per stage for x and y
// DIV_STEPS stages plus a sign/result stage; uses sip_pkg
module sip_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  sip_pkg::div_job_t     in_job,
  output logic                  out_valid,
  output sip_pkg::cross_result_t out_word
);
  import sip_pkg::*;

  // the quotient magnitude is below 2^QUO_BITS on a crossing, so only the
  // low QUO_BITS quotient bits are developed, each as one wide compare and subtract
  localparam int RW = NUM_BITS + 1;

  logic                v   [DIV_STEPS+1];
  logic                hit [DIV_STEPS+1];
  logic                ngx [DIV_STEPS+1];
  logic                ngy [DIV_STEPS+1];
  logic [RW-1:0]       rx  [DIV_STEPS+1];
  logic [RW-1:0]       ry  [DIV_STEPS+1];
  logic [QUO_BITS-1:0] qx  [DIV_STEPS+1];
  logic [QUO_BITS-1:0] qy  [DIV_STEPS+1];
  logic [RW-1:0]       dv  [DIV_STEPS+1];

  always_comb begin
    v[0]   = in_valid;
    hit[0] = in_job.crosses;
    ngx[0] = in_job.neg_x;
    ngy[0] = in_job.neg_y;
    rx[0]  = RW'(in_job.mag_nx);
    ry[0]  = RW'(in_job.mag_ny);
    qx[0]  = '0;
    qy[0]  = '0;
    dv[0]  = RW'(in_job.mag_den);
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - s;
    logic [RW-1:0] tx, ty;
    logic          kx, ky;
    always_comb begin
      tx = dv[s] << SH;
      ty = dv[s] << SH;
      kx = (rx[s] >= tx) && ((dv[s] >> (RW - SH)) == '0);
      ky = (ry[s] >= ty) && ((dv[s] >> (RW - SH)) == '0);
    end
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        hit[s+1] <= hit[s];
        ngx[s+1] <= ngx[s];
        ngy[s+1] <= ngy[s];
        dv[s+1]  <= dv[s];
        rx[s+1]  <= kx ? rx[s] - tx : rx[s];
        ry[s+1]  <= ky ? ry[s] - ty : ry[s];
        qx[s+1]  <= {qx[s][QUO_BITS-2:0], kx};
        qy[s+1]  <= {qy[s][QUO_BITS-2:0], ky};
      end
    end
  end

  logic [QUO_BITS-1:0] sx, sy;
  always_comb begin
    sx = ngx[DIV_STEPS] ? -qx[DIV_STEPS] : qx[DIV_STEPS];
    sy = ngy[DIV_STEPS] ? -qy[DIV_STEPS] : qy[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.crosses <= hit[DIV_STEPS];
      out_word.cross_x <= hit[DIV_STEPS] ? coord_t'(sx[COORD_BITS-1:0]) : '0;
      out_word.cross_y <= hit[DIV_STEPS] ? coord_t'(sy[COORD_BITS-1:0]) : '0;
    end
  end

endmodule

### rtl/segment_intersection_point.sv
// top level of the segment intersection point block
// joins sip_geom and sip_div under one stall; uses sip_pkg
//
// Takes one pair of segments per cycle while in_stall is low and returns one
// word per pair, in order: crosses is set only on a proper crossing (touching,
// collinear and degenerate cases give 0) and the crossing point is truncated
// toward zero, else (0,0). The path runs through five stages of box test,
// products, determinant and numerators, one stage per quotient bit in the
// divider pipeline, and a result stage. The whole pipeline advances when the
// output word is taken or the output register is empty, so a stall holds
// every stage and nothing is lost or repeated.
module segment_intersection_point (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sip_pkg::seg_pair_t     in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sip_pkg::cross_result_t out_word
);
  import sip_pkg::*;

  logic     en;
  logic     gv;
  div_job_t job;

  // advance unless a finished word is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  sip_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .out_valid (gv),
    .out_job   (job)
  );

  sip_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (gv),
    .in_job    (job),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### rtl/sip_check.sv
// port-level checker for segment_intersection_point, bound to the top level
// uses sip_pkg for the result word type
module sip_check (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input sip_pkg::cross_result_t out_word
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("held word changed");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.crosses |-> out_word.cross_x == '0 && out_word.cross_y == '0)
    else $error("point without crossing");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("word after reset");
endmodule

bind segment_intersection_point sip_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
